// ----- design/bbdoq_pkg.sv -----
`timescale 1ns / 1ps
// types, codes and constants for the byte-budgeted drop-oldest queue
// shared by the control, configuration and top-level modules; no dependencies

package bbdoq_pkg;

	localparam int QUEUE_DEPTH = 1024;
	localparam logic [31:0] BYTE_LIMIT_RESET = 32'd67108864;
	localparam int LEN_W = 32;
	localparam int REC_W = 11;
	localparam int TOT_W = 48;

	typedef enum logic [1:0] {
		OP_PUSH        = 2'd0,
		OP_SERVE_BEGIN = 2'd1,
		OP_SERVE_END   = 2'd2,
		OP_CLEAR       = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_PUSHED      = 3'd0,
		STAT_DROPPED     = 3'd1,
		STAT_SERVE_EMPTY = 3'd2,
		STAT_SNAPSHOT    = 3'd3,
		STAT_SERVED      = 3'd4,
		STAT_FAILED      = 3'd5,
		STAT_NO_SERVE    = 3'd6,
		STAT_CLEARED     = 3'd7
	} status_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [LEN_W-1:0]    item_length;
		logic                delivered_ok;
		logic                clear_after;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [REC_W-1:0]    snapshot_records;
		logic [LEN_W-1:0]    snapshot_bytes;
		logic [REC_W-1:0]    records_held;
		logic [LEN_W-1:0]    bytes_held;
		logic [TOT_W-1:0]    dropped_total;
		logic [TOT_W-1:0]    received_total;
		logic [TOT_W-1:0]    served_total;
		logic                serve_active;
	} result_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_APPEND,
		SQ_TRIM_CHK,
		SQ_RD,
		SQ_SUB,
		SQ_REM_CHK,
		SQ_RESP
	} seq_state_t;

	// why the oldest entry is being taken off
	typedef enum logic [1:0] {
		RM_FULL,
		RM_TRIM,
		RM_SERVE
	} rm_mode_t;

endpackage

// ----- design/bbdoq_mem.sv -----
`timescale 1ns / 1ps
// length store: one write port, one read port, registered read data
// depends on nothing but its DEPTH parameter

module bbdoq_mem #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [31:0]                wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [31:0]                rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/bbdoq_cfg.sv -----
`timescale 1ns / 1ps
// apb-style register port holding the byte limit
// uses bbdoq_pkg for the reset value

module bbdoq_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] byte_limit
);
	import bbdoq_pkg::*;

	localparam logic REG_BYTE_LIMIT = 1'b0;

	logic [31:0] limit_q;
	logic        hit;

	assign hit    = (paddr[2] == REG_BYTE_LIMIT);
	assign pready = 1'b1;
	assign prdata = hit ? limit_q : 32'd0;
	assign byte_limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= BYTE_LIMIT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			limit_q <= pwdata;
		end
	end

endmodule

// ----- design/bbdoq_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer and counters: pointer ring over the length store, byte budget,
// serve snapshot and totals; uses bbdoq_pkg, drives a bbdoq_mem port

module bbdoq_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bbdoq_pkg::cmd_t            cmd,
	output logic                       busy,
	output logic                       done,
	output bbdoq_pkg::result_t         result,
	input  logic [31:0]                byte_limit,
	output logic                       mem_wr_en,
	output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
	output logic [31:0]                mem_wr_data,
	output logic                       mem_rd_en,
	output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
	input  logic [31:0]                mem_rd_data
);
	import bbdoq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	seq_state_t        state_q, state_d;
	logic [PW-1:0]     head_q, tail_q;
	logic [CW-1:0]     count_q, snap_q, rem_q;
	logic [32:0]       bytes_q;
	logic [TOT_W-1:0]  dropped_q, received_q, served_q;
	logic              serving_q;
	logic              done_q;
	result_t           result_q;

	logic [31:0]       len_q;
	logic [32:0]       charge_q;
	rm_mode_t          mode_q;
	status_t           status_q;
	logic [CW-1:0]     snap_rec_q;
	logic [31:0]       snap_bytes_q;

	logic              accept;
	logic [32:0]       charge_in, charge_rd, limit_ext;
	logic              push_drop, store_full, serve_remove, trim_more, rem_more;
	logic [PW-1:0]     head_next, tail_next;

	assign accept     = start && (state_q == SQ_IDLE);
	assign limit_ext  = {1'b0, byte_limit};
	assign charge_in  = {1'b0, cmd.item_length} + 33'd1;
	assign charge_rd  = {1'b0, mem_rd_data} + 33'd1;
	assign push_drop  = charge_in > limit_ext;
	assign store_full = (count_q == CW'(DEPTH));
	assign serve_remove = serving_q && cmd.delivered_ok && cmd.clear_after;
	assign trim_more  = (bytes_q > limit_ext) && (count_q != '0);
	assign rem_more   = (rem_q != '0) && (count_q != '0);
	assign head_next  = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next  = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					case (cmd.opcode)
						OP_PUSH: begin
							if (push_drop) begin
								state_d = SQ_RESP;
							end else if (store_full) begin
								state_d = SQ_RD;
							end else begin
								state_d = SQ_APPEND;
							end
						end
						OP_SERVE_END: state_d = serve_remove ? SQ_REM_CHK : SQ_RESP;
						default:      state_d = SQ_RESP;
					endcase
				end
			end
			SQ_APPEND:   state_d = SQ_TRIM_CHK;
			SQ_TRIM_CHK: state_d = trim_more ? SQ_RD : SQ_RESP;
			SQ_RD:       state_d = SQ_SUB;
			SQ_SUB: begin
				case (mode_q)
					RM_FULL:  state_d = SQ_APPEND;
					RM_TRIM:  state_d = SQ_TRIM_CHK;
					default:  state_d = SQ_REM_CHK;
				endcase
			end
			SQ_REM_CHK:  state_d = rem_more ? SQ_RD : SQ_RESP;
			SQ_RESP:     state_d = SQ_IDLE;
			default:     state_d = SQ_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy        = (state_q != SQ_IDLE);
		mem_rd_en   = (state_q == SQ_RD);
		mem_rd_addr = head_q;
		mem_wr_en   = (state_q == SQ_APPEND);
		mem_wr_addr = tail_q;
		mem_wr_data = len_q;
	end

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			bytes_q    <= '0;
			dropped_q  <= '0;
			received_q <= '0;
			served_q   <= '0;
			serving_q  <= 1'b0;
			snap_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SQ_RESP);
			case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							OP_PUSH: begin
								if (push_drop) begin
									dropped_q <= dropped_q + 1'b1;
								end
							end
							OP_SERVE_BEGIN: begin
								if (!serving_q && count_q != '0) begin
									snap_q    <= count_q;
									serving_q <= 1'b1;
								end
							end
							OP_SERVE_END: begin
								if (serving_q) begin
									serving_q <= 1'b0;
									snap_q    <= '0;
									if (cmd.delivered_ok) begin
										served_q <= served_q + TOT_W'(snap_q);
									end
								end
							end
							OP_CLEAR: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
								bytes_q <= '0;
							end
							default: ;
						endcase
					end
				end
				SQ_APPEND: begin
					tail_q     <= tail_next;
					count_q    <= count_q + 1'b1;
					bytes_q    <= bytes_q + charge_q;
					received_q <= received_q + 1'b1;
				end
				SQ_SUB: begin
					bytes_q <= (bytes_q >= charge_rd) ? bytes_q - charge_rd : '0;
					head_q  <= head_next;
					count_q <= count_q - 1'b1;
					if (mode_q != RM_SERVE) begin
						dropped_q <= dropped_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// per-item working registers and the result register
	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					len_q        <= cmd.item_length;
					charge_q     <= charge_in;
					snap_rec_q   <= '0;
					snap_bytes_q <= '0;
					rem_q        <= snap_q;
					case (cmd.opcode)
						OP_PUSH: begin
							mode_q   <= RM_FULL;
							status_q <= push_drop ? STAT_DROPPED : STAT_PUSHED;
						end
						OP_SERVE_BEGIN: begin
							mode_q <= RM_SERVE;
							if (serving_q || count_q == '0) begin
								status_q <= STAT_SERVE_EMPTY;
							end else begin
								status_q     <= STAT_SNAPSHOT;
								snap_rec_q   <= count_q;
								snap_bytes_q <= bytes_q[31:0];
							end
						end
						OP_SERVE_END: begin
							mode_q <= RM_SERVE;
							if (!serving_q) begin
								status_q <= STAT_NO_SERVE;
							end else if (cmd.delivered_ok) begin
								status_q <= STAT_SERVED;
							end else begin
								status_q <= STAT_FAILED;
							end
						end
						default: begin
							mode_q   <= RM_SERVE;
							status_q <= STAT_CLEARED;
						end
					endcase
				end
			end
			SQ_APPEND: mode_q <= RM_TRIM;
			SQ_SUB: begin
				if (mode_q == RM_SERVE) begin
					rem_q <= rem_q - 1'b1;
				end
			end
			SQ_RESP: begin
				result_q.status           <= status_q;
				result_q.snapshot_records <= REC_W'(snap_rec_q);
				result_q.snapshot_bytes   <= snap_bytes_q;
				result_q.records_held     <= REC_W'(count_q);
				result_q.bytes_held       <= bytes_q[31:0];
				result_q.dropped_total    <= dropped_q;
				result_q.received_total   <= received_q;
				result_q.served_total     <= served_q;
				result_q.serve_active     <= serving_q;
			end
			default: ;
		endcase
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count above store depth");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (bytes_q == '0))
		else $error("bytes held with no records");

	a_push_within_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_RESP && status_q == STAT_PUSHED) |-> (bytes_q <= limit_ext))
		else $error("push finished above byte limit");

	a_single_port_use: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd_en && mem_wr_en))
		else $error("store read and written in one cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

endmodule

// ----- design/byte_budget_drop_oldest_queue_top.sv -----
`timescale 1ns / 1ps
// byte-budgeted drop-oldest queue descriptor manager, top level
// uses bbdoq_pkg; instantiates bbdoq_cfg, bbdoq_ctrl and bbdoq_mem
//
// usage:
//   a command transfers on a rising edge with start high and busy low;
//   cmd carries opcode (push, serve begin, serve end, clear), item_length,
//   delivered_ok and clear_after. exactly one result per command shows on
//   result for a single cycle with done high; the receiver cannot stall it.
//   the byte limit sits at apb address 0; the user must write it only
//   while idle, as the block itself does not enforce this.
// sequence (states from accept back to idle):
//   serve begin, clear, refused push, serve end without removal: response
//   push: a removal if the store was full, append, trim checks and a
//     removal per entry evicted over the byte budget, then response
//   serve end with removal: removal checks and removals, then response
//   a removal reads the length store, then updates head, count and bytes
//   done is registered from the response step; busy drops with it
// reset: the queue is empty, counters are zero, no serve is active and the
//   byte limit is 64M; the length store itself is not cleared.

module byte_budget_drop_oldest_queue_top #(
	parameter int DEPTH = bbdoq_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bbdoq_pkg::cmd_t     cmd,
	output logic                busy,
	output logic                done,
	output bbdoq_pkg::result_t  result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import bbdoq_pkg::*;

	localparam int PW = $clog2(DEPTH);

	logic [31:0]    byte_limit;
	logic           mem_wr_en, mem_rd_en;
	logic [PW-1:0]  mem_wr_addr, mem_rd_addr;
	logic [31:0]    mem_wr_data, mem_rd_data;

	bbdoq_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.byte_limit (byte_limit)
	);

	bbdoq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.byte_limit  (byte_limit),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	bbdoq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

// ----- sim/tb_byte_budget_drop_oldest_queue_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for the byte-budgeted drop-oldest queue top level
// directed table then random phases; results checked against a local queue model or typed rows
// uses bbdoq_pkg

module tb_byte_budget_drop_oldest_queue_top;

	import bbdoq_pkg::*;

	localparam logic [2:0] ADDR_BYTE_LIMIT = 3'd0;
	// ~1140 commands; base steps, evictions, removals and idle gaps stay well under this limit
	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 16;

	typedef enum {ROW_CMD, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		cmd_t        c;
		logic [31:0] limit_val;
		bit          typed;
		result_t     want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// local copy of the queue state
	logic [31:0] len_mem [QUEUE_DEPTH];
	int unsigned head_idx = 0;
	int unsigned tail_idx = 0;
	int unsigned held_cnt = 0;
	int unsigned snap_cnt = 0;
	logic [63:0] held_bytes = '0;
	logic [47:0] drop_tot = '0;
	logic [47:0] recv_tot = '0;
	logic [47:0] serv_tot = '0;
	bit          serving = 1'b0;
	logic [31:0] limit_reg = BYTE_LIMIT_RESET;

	result_t outcomes_due [$];
	row_t    dir_rows [$];
	bit      use_typed = 1'b0;
	result_t typed_want = '0;
	int      mismatch_cnt = 0;
	int      cycle_cnt = 0;

	byte_budget_drop_oldest_queue_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void take_oldest();
		logic [63:0] charge;
		if (held_cnt == 0)
			return;
		charge = {32'd0, len_mem[head_idx]} + 64'd1;
		held_bytes = (held_bytes >= charge) ? held_bytes - charge : 64'd0;
		head_idx = (head_idx + 1) % QUEUE_DEPTH;
		held_cnt--;
	endfunction

	function automatic void evict_oldest();
		if (held_cnt == 0)
			return;
		take_oldest();
		drop_tot++;
	endfunction

	function automatic result_t queue_outcome(cmd_t c);
		result_t r;
		logic [63:0] charge;
		int unsigned n;
		r = '0;
		case (c.opcode)
		OP_PUSH: begin
			charge = {32'd0, c.item_length} + 64'd1;
			if (charge > {32'd0, limit_reg}) begin
				drop_tot++;
				r.status = STAT_DROPPED;
			end else begin
				if (held_cnt >= QUEUE_DEPTH)
					evict_oldest();
				len_mem[tail_idx] = c.item_length;
				tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
				held_cnt++;
				held_bytes += charge;
				recv_tot++;
				while (held_bytes > {32'd0, limit_reg} && held_cnt > 0)
					evict_oldest();
				r.status = STAT_PUSHED;
			end
		end
		OP_SERVE_BEGIN: begin
			if (serving || held_cnt == 0) begin
				r.status = STAT_SERVE_EMPTY;
			end else begin
				snap_cnt = held_cnt;
				serving = 1'b1;
				r.snapshot_records = held_cnt[REC_W-1:0];
				r.snapshot_bytes = held_bytes[31:0];
				r.status = STAT_SNAPSHOT;
			end
		end
		OP_SERVE_END: begin
			if (!serving) begin
				r.status = STAT_NO_SERVE;
			end else begin
				serving = 1'b0;
				if (c.delivered_ok) begin
					serv_tot += snap_cnt;
					// entries evicted during the serve are replaced by newer ones
					if (c.clear_after) begin
						n = snap_cnt;
						while (n > 0 && held_cnt > 0) begin
							take_oldest();
							n--;
						end
					end
					r.status = STAT_SERVED;
				end else begin
					r.status = STAT_FAILED;
				end
				snap_cnt = 0;
			end
		end
		default: begin
			head_idx = 0;
			tail_idx = 0;
			held_cnt = 0;
			held_bytes = '0;
			r.status = STAT_CLEARED;
		end
		endcase
		r.records_held = held_cnt[REC_W-1:0];
		r.bytes_held = held_bytes[31:0];
		r.dropped_total = drop_tot;
		r.received_total = recv_tot;
		r.served_total = serv_tot;
		r.serve_active = serving;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("mismatch %s: expected %0h got %0h", name, want, got);
		end
	endtask

	task automatic check_result(result_t want, result_t got);
		check_field("status", 64'(want.status), 64'(got.status));
		check_field("snapshot_records", 64'(want.snapshot_records),
			64'(got.snapshot_records));
		check_field("snapshot_bytes", 64'(want.snapshot_bytes), 64'(got.snapshot_bytes));
		check_field("records_held", 64'(want.records_held), 64'(got.records_held));
		check_field("bytes_held", 64'(want.bytes_held), 64'(got.bytes_held));
		check_field("dropped_total", 64'(want.dropped_total), 64'(got.dropped_total));
		check_field("received_total", 64'(want.received_total), 64'(got.received_total));
		check_field("served_total", 64'(want.served_total), 64'(got.served_total));
		check_field("serve_active", 64'(want.serve_active), 64'(got.serve_active));
	endtask

	// results retire before a new command transfer is predicted
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: result with none expected, status %0d", result.status);
				end else begin
					want = outcomes_due.pop_front();
					check_result(want, result);
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_BYTE_LIMIT)
				limit_reg = pwdata;
			if (start && !busy) begin
				want = queue_outcome(cmd);
				if (use_typed)
					want = typed_want;
				outcomes_due.push_back(want);
			end
		end
	end

	function automatic result_t held_view(status_t s, logic [10:0] rec, logic [31:0] bytes,
			logic [47:0] drops, logic [47:0] recvs);
		result_t r;
		r = '0;
		r.status = s;
		r.records_held = rec;
		r.bytes_held = bytes;
		r.dropped_total = drops;
		r.received_total = recvs;
		return r;
	endfunction

	function automatic void add_cmd(opcode_t op, logic [31:0] len, bit ok, bit clr,
			bit typed = 1'b0, result_t want = '0);
		row_t row;
		row.kind = ROW_CMD;
		row.c.opcode = op;
		row.c.item_length = len;
		row.c.delivered_ok = ok;
		row.c.clear_after = clr;
		row.limit_val = '0;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_limit(logic [31:0] val);
		row_t row;
		row.kind = ROW_LIMIT;
		row.c = '0;
		row.limit_val = val;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic wait_quiet();
		start = 1'b0;
		while (outcomes_due.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_limit(logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_BYTE_LIMIT;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_cmd(cmd_t c, bit typed, result_t want);
		cmd = c;
		use_typed = typed;
		typed_want = want;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		use_typed = 1'b0;
	endtask

	task automatic idle_gap(int pct);
		while ($urandom_range(99) < pct) begin
			start = 1'b0;
			@(negedge clk);
		end
	endtask

	// a phase with no clears also never removes entries at serve end
	task automatic run_phase(int n_items, int idle_pct, int push_pct, int clear_pct,
			int unsigned len_hi, int wide_pct);
		cmd_t c;
		int pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			c.delivered_ok = ($urandom_range(3) != 0);
			c.clear_after = (clear_pct != 0) && ($urandom_range(1) != 0);
			if ($urandom_range(99) < wide_pct) begin
				c.item_length = $urandom;
				if (c.item_length == 32'hFFFF_FFFF)
					c.item_length = 32'hFFFF_FFFE;
			end else begin
				c.item_length = $urandom_range(len_hi);
			end
			if (pick < push_pct)
				c.opcode = OP_PUSH;
			else if (pick < push_pct + clear_pct)
				c.opcode = OP_CLEAR;
			else if (pick % 2 == 0)
				c.opcode = OP_SERVE_BEGIN;
			else
				c.opcode = OP_SERVE_END;
			if ($urandom_range(49) == 0)
				wait_quiet();
			idle_gap(idle_pct);
			send_cmd(c, 1'b0, '0);
		end
		start = 1'b0;
	endtask

	initial begin
		logic [31:0] lim;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		add_cmd(OP_SERVE_END, 32'd0, 1'b1, 1'b1, 1'b1,
			held_view(STAT_NO_SERVE, 11'd0, 32'd0, 48'd0, 48'd0));
		add_cmd(OP_SERVE_BEGIN, 32'd0, 1'b0, 1'b0, 1'b1,
			held_view(STAT_SERVE_EMPTY, 11'd0, 32'd0, 48'd0, 48'd0));
		add_cmd(OP_PUSH, 32'd0, 1'b0, 1'b0, 1'b1,
			held_view(STAT_PUSHED, 11'd1, 32'd1, 48'd0, 48'd1));
		add_cmd(OP_PUSH, 32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1,
			held_view(STAT_DROPPED, 11'd1, 32'd1, 48'd1, 48'd1));
		// exactly the budget: the older entry goes
		add_cmd(OP_PUSH, 32'd67108863, 1'b0, 1'b0, 1'b1,
			held_view(STAT_PUSHED, 11'd1, 32'd67108864, 48'd2, 48'd2));
		add_cmd(OP_PUSH, 32'd67108864, 1'b0, 1'b0, 1'b1,
			held_view(STAT_DROPPED, 11'd1, 32'd67108864, 48'd3, 48'd2));
		add_cmd(OP_PUSH, 32'd9, 1'b0, 1'b0);
		add_cmd(OP_SERVE_BEGIN, 32'd0, 1'b0, 1'b0);
		add_cmd(OP_SERVE_BEGIN, 32'd0, 1'b1, 1'b1);
		add_cmd(OP_PUSH, 32'd5, 1'b1, 1'b0);
		add_cmd(OP_SERVE_END, 32'd0, 1'b0, 1'b1);
		add_cmd(OP_SERVE_BEGIN, 32'd0, 1'b0, 1'b0);
		add_cmd(OP_SERVE_END, 32'd0, 1'b1, 1'b0);
		add_cmd(OP_SERVE_BEGIN, 32'd0, 1'b0, 1'b0);
		// clear in the middle of a serve keeps the serve open
		add_cmd(OP_CLEAR, 32'd0, 1'b0, 1'b0);
		add_cmd(OP_PUSH, 32'd3, 1'b0, 1'b1);
		add_cmd(OP_SERVE_END, 32'd0, 1'b1, 1'b1);
		add_limit(32'd0);
		add_cmd(OP_PUSH, 32'd0, 1'b0, 1'b0);
		add_limit(32'hFFFF_FFFF);
		add_cmd(OP_PUSH, 32'hFFFF_FFFE, 1'b0, 1'b0);
		add_cmd(OP_PUSH, 32'd0, 1'b0, 1'b0);
		add_cmd(OP_PUSH, 32'd100, 1'b0, 1'b0);
		// limit drops under the held bytes, trimmed by the next push
		add_limit(32'd50);
		add_cmd(OP_SERVE_BEGIN, 32'd0, 1'b0, 1'b0);
		add_cmd(OP_PUSH, 32'd1, 1'b0, 1'b0);
		add_cmd(OP_SERVE_END, 32'd0, 1'b1, 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_LIMIT) begin
				wait_quiet();
				write_limit(dir_rows[i].limit_val);
			end else begin
				send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		wait_quiet();
		write_limit(BYTE_LIMIT_RESET);
		run_phase(15, 0, 55, 5, 32'd16777216, 10);

		wait_quiet();
		write_limit($urandom_range(400, 40));
		run_phase(20, 73, 60, 4, 150, 5);

		wait_quiet();
		write_limit(32'd1);
		run_phase(8, 17, 70, 5, 2, 5);

		// small items, no clears: runs the store full and past it
		wait_quiet();
		write_limit(32'hFFFF_FFFF);
		run_phase(1060, 17, 98, 0, 63, 0);

		wait_quiet();
		lim = $urandom;
		if (lim == 32'd0)
			lim = 32'd1;
		write_limit(lim);
		run_phase(12, 73, 50, 8, 1000, 30);

		wait_quiet();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0 && outcomes_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- byte_budget_drop_oldest_queue_top.f -----
design/bbdoq_pkg.sv
design/bbdoq_mem.sv
design/bbdoq_cfg.sv
design/bbdoq_ctrl.sv
design/byte_budget_drop_oldest_queue_top.sv
sim/tb_byte_budget_drop_oldest_queue_top.sv
